// ===== rtl/stq_pkg.sv =====
// Shared types and constants for the sorted timeout queue.
// Used by the queue cell and the top level; depends on nothing else.
package stq_pkg;

  localparam int TIMER_ID_W = 4;
  localparam int CMD_W      = 2;
  localparam int OUT_TICK_W = 64;
  localparam int MAX_FIRED  = 16;
  localparam int FIRE_CNT_W = $clog2(MAX_FIRED);

  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EXPIRE  = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_POP    = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [TIMER_ID_W-1:0] id;
  } cell_ctl_t;

endpackage

// ===== rtl/stq_cmd_if.sv =====
// Command channel of the sorted timeout queue: valid/ready plus one command item.
// No dependencies.
interface stq_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  timer_id;
  logic [63:0] deadline;
  logic [63:0] current_time;

  modport source (output valid, cmd, timer_id, deadline, current_time, input ready);
  modport sink   (input valid, cmd, timer_id, deadline, current_time, output ready);
endinterface

// ===== rtl/stq_res_if.sv =====
// Result channel of the sorted timeout queue: valid/ready plus one result item.
// No dependencies.
interface stq_res_if;
  logic        valid;
  logic        ready;
  logic        fired;
  logic [3:0]  fired_id;
  logic [63:0] next_deadline;
  logic        armed;
  logic        status;
  logic        last;

  modport source (output valid, fired, fired_id, next_deadline, armed, status, last,
                  input ready);
  modport sink   (input valid, fired, fired_id, next_deadline, armed, status, last,
                  output ready);
endinterface

// ===== rtl/stq_cell.sv =====
// One slot of the sorted timer chain: holds a timer id and deadline and shifts
// toward either neighbor on insert, remove and pop. Depends on stq_pkg.
module stq_cell
  import stq_pkg::*;
#(
  parameter int TICK_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctl_t             ctl,
  input  logic [TICK_BITS-1:0]  new_dl,
  input  logic                  l_after,
  input  logic                  l_v,
  input  logic [TIMER_ID_W-1:0] l_id,
  input  logic [TICK_BITS-1:0]  l_dl,
  input  logic                  r_v,
  input  logic [TIMER_ID_W-1:0] r_id,
  input  logic [TICK_BITS-1:0]  r_dl,
  input  logic                  hit_in,
  output logic                  v,
  output logic [TIMER_ID_W-1:0] id,
  output logic [TICK_BITS-1:0]  dl,
  output logic                  after,
  output logic                  hit_out,
  output logic                  same
);

  logic                  match;
  logic                  v_next;
  logic [TIMER_ID_W-1:0] id_next;
  logic [TICK_BITS-1:0]  dl_next;

  assign match   = v && (id == ctl.id);
  assign hit_out = hit_in || match;
  assign same    = match && (dl == new_dl);
  // A new entry goes behind every entry whose deadline is not later than its own.
  assign after   = v && (dl <= new_dl);

  always_comb begin
    v_next  = v;
    id_next = id;
    dl_next = dl;
    case (ctl.op)
      OP_INSERT: begin
        if (!after) begin
          if (l_after) begin
            v_next  = 1'b1;
            id_next = ctl.id;
            dl_next = new_dl;
          end else begin
            v_next  = l_v;
            id_next = l_id;
            dl_next = l_dl;
          end
        end
      end
      OP_REMOVE: begin
        if (hit_out) begin
          v_next  = r_v;
          id_next = r_id;
          dl_next = r_dl;
        end
      end
      OP_POP: begin
        v_next  = r_v;
        id_next = r_id;
        dl_next = r_dl;
      end
      default: begin
        v_next = v;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else begin
      v <= v_next;
    end
    id <= id_next;
    dl <= dl_next;
  end

endmodule

// ===== rtl/sorted_timeout_queue_core.sv =====
// Sorted timeout queue: keeps up to NUM_TIMERS timers ordered by deadline in a
// chain of cells, ties in arrival order.
// Channels: cmd_in takes one command item (enqueue, dequeue, update, expire);
// res_out gives result items, each with the earliest deadline left and armed.
// Enqueue, dequeue and update give one result. The command is registered, the
// chain is updated in state S_OP (and in S_INS too when update re-times a queued
// timer, as a remove followed by an insert), and the result is loaded into the
// output register in S_REPORT once that register is free; the next command is
// taken when the queue is back in S_IDLE.
// Expire pops the head of the chain once per cycle, one result per cycle while
// the receiver takes them, up to 16 results; the last one carries last. With
// nothing due it gives one result with fired low.
// A command goes through the chain one at a time: the next item is accepted in
// the cycle after the previous one has loaded its final result.
// When the receiver stalls, the output register holds its item and the chain
// waits; no result is dropped. Reset (rst, synchronous) empties the chain and
// the output register, and the queue reports no deadline (all ones).
module sorted_timeout_queue_core
  import stq_pkg::*;
#(
  parameter int NUM_TIMERS = 16,
  parameter int TICK_BITS  = 64
) (
  input logic      clk,
  input logic      rst,
  stq_cmd_if.sink  cmd_in,
  stq_res_if.source res_out
);

  localparam logic [TICK_BITS-1:0] INVALID_TIMEOUT = {TICK_BITS{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_OP     = 5'b00010,
    S_INS    = 5'b00100,
    S_REPORT = 5'b01000,
    S_EXPIRE = 5'b10000
  } state_t;

  state_t                state, state_next;
  logic [CMD_W-1:0]      c_cmd;
  logic [TIMER_ID_W-1:0] c_id;
  logic                  c_id_ok;
  logic [TICK_BITS-1:0]  c_dl;
  logic [TICK_BITS-1:0]  c_now;
  logic                  status, status_next;
  logic [FIRE_CNT_W-1:0] fire_cnt;

  logic                  out_valid;
  logic                  out_fired;
  logic [TIMER_ID_W-1:0] out_id;
  logic [OUT_TICK_W-1:0] out_dl;
  logic                  out_armed;
  logic                  out_status;
  logic                  out_last;

  cell_ctl_t             ctl;
  logic [NUM_TIMERS-1:0] cell_v;
  logic [NUM_TIMERS-1:0] cell_after;
  logic [NUM_TIMERS-1:0] cell_same;
  logic [NUM_TIMERS:0]   hit;
  logic [TIMER_ID_W-1:0] cell_id [NUM_TIMERS];
  logic [TICK_BITS-1:0]  cell_dl [NUM_TIMERS];

  logic                  accept;
  logic                  out_free;
  logic                  present;
  logic                  due_head;
  logic                  due_second;
  logic                  load;
  logic                  ld_fired;
  logic [TIMER_ID_W-1:0] ld_id;
  logic [OUT_TICK_W-1:0] ld_dl;
  logic                  ld_armed;
  logic                  ld_status;
  logic                  ld_last;
  logic [TICK_BITS-1:0]  in_dl;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic                  l_after, l_v, r_v;
    logic [TIMER_ID_W-1:0] l_id, r_id;
    logic [TICK_BITS-1:0]  l_dl, r_dl;

    if (i == 0) begin : g_head
      assign l_after = 1'b1;
      assign l_v     = 1'b0;
      assign l_id    = '0;
      assign l_dl    = '0;
    end else begin : g_mid
      assign l_after = cell_after[i-1];
      assign l_v     = cell_v[i-1];
      assign l_id    = cell_id[i-1];
      assign l_dl    = cell_dl[i-1];
    end

    if (i == NUM_TIMERS - 1) begin : g_tail
      assign r_v  = 1'b0;
      assign r_id = '0;
      assign r_dl = '0;
    end else begin : g_body
      assign r_v  = cell_v[i+1];
      assign r_id = cell_id[i+1];
      assign r_dl = cell_dl[i+1];
    end

    stq_cell #(
      .TICK_BITS (TICK_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .new_dl  (c_dl),
      .l_after (l_after),
      .l_v     (l_v),
      .l_id    (l_id),
      .l_dl    (l_dl),
      .r_v     (r_v),
      .r_id    (r_id),
      .r_dl    (r_dl),
      .hit_in  (hit[i]),
      .v       (cell_v[i]),
      .id      (cell_id[i]),
      .dl      (cell_dl[i]),
      .after   (cell_after[i]),
      .hit_out (hit[i+1]),
      .same    (cell_same[i])
    );
  end

  assign cmd_in.ready = (state == S_IDLE);
  assign accept       = cmd_in.valid && cmd_in.ready;
  assign out_free     = !out_valid || res_out.ready;
  assign present      = hit[NUM_TIMERS];
  assign due_head     = cell_v[0] && (cell_dl[0] <= c_now);
  assign due_second   = cell_v[1] && (cell_dl[1] <= c_now);

  // All ones is reserved for an empty queue, so such a deadline saturates.
  always_comb begin
    in_dl = cmd_in.deadline[TICK_BITS-1:0];
    if (in_dl == INVALID_TIMEOUT) begin
      in_dl = INVALID_TIMEOUT - 1'b1;
    end
  end

  always_comb begin
    state_next  = state;
    status_next = status;
    ctl.op      = OP_HOLD;
    ctl.id      = c_id;
    load        = 1'b0;
    ld_fired    = 1'b0;
    ld_id       = '0;
    ld_dl       = cell_v[0] ? OUT_TICK_W'(cell_dl[0]) : OUT_TICK_W'(INVALID_TIMEOUT);
    ld_armed    = cell_v[0];
    ld_status   = status;
    ld_last     = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (cmd_in.cmd == CMD_EXPIRE) ? S_EXPIRE : S_OP;
        end
      end
      S_OP: begin
        state_next  = S_REPORT;
        status_next = 1'b0;
        if (c_id_ok) begin
          case (c_cmd)
            CMD_ENQUEUE: begin
              if (present) begin
                status_next = 1'b1;
              end else begin
                ctl.op = OP_INSERT;
              end
            end
            CMD_DEQUEUE: begin
              if (present) begin
                ctl.op = OP_REMOVE;
              end
            end
            CMD_UPDATE: begin
              if (!present) begin
                ctl.op = OP_INSERT;
              end else if (!(|cell_same)) begin
                ctl.op     = OP_REMOVE;
                state_next = S_INS;
              end
            end
            default: begin
              ctl.op = OP_HOLD;
            end
          endcase
        end
      end
      S_INS: begin
        ctl.op     = OP_INSERT;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EXPIRE: begin
        ld_status = 1'b0;
        if (out_free) begin
          load = 1'b1;
          if (due_head) begin
            ctl.op   = OP_POP;
            ld_fired = 1'b1;
            ld_id    = cell_id[0];
            ld_dl    = cell_v[1] ? OUT_TICK_W'(cell_dl[1]) : OUT_TICK_W'(INVALID_TIMEOUT);
            ld_armed = cell_v[1];
            ld_last  = (fire_cnt == FIRE_CNT_W'(MAX_FIRED - 1)) || !due_second;
          end
          if (ld_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      status    <= 1'b0;
      fire_cnt  <= '0;
    end else begin
      state     <= state_next;
      out_valid <= load || (out_valid && !res_out.ready);
      status    <= status_next;
      if (accept) begin
        fire_cnt <= '0;
      end else if (ctl.op == OP_POP) begin
        fire_cnt <= fire_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_cmd   <= cmd_in.cmd;
      c_id    <= cmd_in.timer_id;
      c_id_ok <= (int'(cmd_in.timer_id) < NUM_TIMERS);
      c_dl    <= in_dl;
      c_now   <= cmd_in.current_time[TICK_BITS-1:0];
    end
    if (load) begin
      out_fired  <= ld_fired;
      out_id     <= ld_id;
      out_dl     <= ld_dl;
      out_armed  <= ld_armed;
      out_status <= ld_status;
      out_last   <= ld_last;
    end
  end

  assign res_out.valid         = out_valid;
  assign res_out.fired         = out_fired;
  assign res_out.fired_id      = out_id;
  assign res_out.next_deadline = out_dl;
  assign res_out.armed         = out_armed;
  assign res_out.status        = out_status;
  assign res_out.last          = out_last;

  // Stored deadlines never hold the empty marker, so armed follows the deadline.
  a_armed_matches_deadline: assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> (res_out.armed == (res_out.next_deadline
                                         != OUT_TICK_W'(INVALID_TIMEOUT))))
    else $error("armed disagrees with next_deadline");

  a_fired_has_no_status: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.fired) |-> !res_out.status)
    else $error("expired timer result carries a status");

  for (genvar k = 0; k < NUM_TIMERS - 1; k++) begin : g_order_chk
    a_chain_sorted: assert property (@(posedge clk) disable iff (rst)
      cell_v[k+1] |-> (cell_v[k] && (cell_dl[k] <= cell_dl[k+1])))
      else $error("timer chain is out of order or has a gap");
  end

endmodule
